>>> sv/hgdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgdt_pkg: shared types and constants
// Types, register indexes and frame kinds for the GOP and DPB tracker.
// ----------------------------------------------------------------------------
package hgdt_pkg;

  localparam int DpbDepth  = 16;
  localparam int LongSlots = 16;
  localparam int IdxW      = $clog2(DpbDepth);
  localparam int CntW      = $clog2(DpbDepth + 1);

  localparam logic [1:0] KIND_IDR = 2'd0;
  localparam logic [1:0] KIND_I   = 2'd1;
  localparam logic [1:0] KIND_P   = 2'd2;
  localparam logic [1:0] KIND_B   = 2'd3;

  localparam logic [1:0] REG_GOP_LENGTH = 2'd0;
  localparam logic [1:0] REG_P_PERIOD   = 2'd1;
  localparam logic [1:0] REG_DPB_CAP    = 2'd2;
  localparam logic [1:0] REG_MAX_LONG   = 2'd3;

  typedef struct packed {
    logic        force_key;
    logic        mark_ltr;
    logic [3:0]  mark_ltr_slot;
    logic        use_ltr;
    logic [15:0] use_ltr_mask;
    logic [31:0] dirty_frame_num;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [31:0] frame_poc;
    logic        frame_is_long;
    logic [31:0] long_term_info;
    logic [4:0]  ref_position;
    logic        ref_valid;
    logic [31:0] entry_poc;
    logic        entry_is_long;
    logic [31:0] entry_dirty_num;
    logic        entry_is_current;
    logic        ref_error;
    logic        last;
  } out_item_t;

  // DPB entry as held in the shift store
  typedef struct packed {
    logic [31:0] poc;
    logic        is_long;
    logic [3:0]  slot;
    logic [31:0] dirty;
  } dpb_entry_t;

  // Divider handshake between sequencer and modulo unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_P,
    ST_KIND,
    ST_PRUNE,
    ST_MAX,
    ST_EMIT,
    ST_EVICT,
    ST_REUSE,
    ST_APPEND,
    ST_MOD_G,
    ST_DONE
  } state_e;

endpackage

>>> sv/hgdt_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgdt_mod: iterative remainder unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module hgdt_mod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hgdt_pkg::div_req_t req_i,
  output hgdt_pkg::div_rsp_t rsp_o
);
  import hgdt_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_q[31:0], num_q[31]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      rem_d = diff[32] ? shifted : diff;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[31:0];

endmodule

>>> sv/hevc_gop_and_dpb_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_gop_and_dpb_tracker: GOP position and DPB reference tracker
// Picks each frame's kind, POC and L0 reference and streams the DPB snapshot.
// ----------------------------------------------------------------------------
// Usage: raise start_i with in_i for one frame while busy_o is low; the
// transfer happens at that edge and busy_o stays high until the frame is
// finished. Results come out one per cycle on out_o, marked by out_valid_o,
// one per DPB entry in order and then the current frame with last set. The
// receiver cannot stall; each result is present for exactly one cycle.
// Configuration writes go through cfg_valid_i/cfg_ready_o with cfg_index_i
// and cfg_data_i; ready is high while no frame is in flight and start_i is low.
// Sequence: the P-period remainder (skipped when it is not needed), the
// frame kind, pruning (P frames that use long-term references), the max-POC
// scan (P frames), the snapshot, eviction and slot reuse, the append, then
// the GOP-length remainder (skipped when the GOP is infinite). The remainder
// unit is bit-serial and shared by both remainders; the DPB store is walked
// one entry per cycle.
// Reset: all counters, the pending mark and the DPB fill count clear; the
// registers take gop_length 0, p_period 1, dpb_capacity 16, max_long_term 0.
// ----------------------------------------------------------------------------
module hevc_gop_and_dpb_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  hgdt_pkg::in_item_t   in_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  output hgdt_pkg::out_item_t  out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import hgdt_pkg::*;

  state_e state_q, state_d;

  logic [15:0] gop_len_q;
  logic [7:0]  p_per_q;
  logic [4:0]  cap_q;
  logic [4:0]  max_lt_q;

  logic [31:0] gop_pos_q, gop_pos_d;
  logic [31:0] poc_q, poc_d;
  logic        pend_q, pend_d;
  logic [3:0]  pend_slot_q, pend_slot_d;
  logic [3:0]  cur_slot_q, cur_slot_d;
  logic [15:0] act_mask_q, act_mask_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  dpb_entry_t  dpb_q [DpbDepth];
  in_item_t    item_q;
  logic [1:0]  kind_q, kind_d;
  logic        is_long_q, is_long_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] ref_q, ref_d;
  logic        ref_valid_q, ref_valid_d;
  logic        ref_err_q, ref_err_d;
  logic [15:0] used_q, used_d;
  logic        rem_zero_q, rem_zero_d;

  // Shift-remove request: close the gap at rm_pos
  logic            rm_en;
  logic [IdxW-1:0] rm_pos;
  logic            app_en;

  div_req_t   dreq;
  div_rsp_t   drsp;

  logic [IdxW-1:0] idx_w;
  dpb_entry_t      cur_e;
  dpb_entry_t      ref_e;
  logic [4:0]      cap_c;
  logic            accept;

  assign accept      = start_i && state_q == ST_IDLE;
  assign busy_o      = state_q != ST_IDLE;
  assign cfg_ready_o = state_q == ST_IDLE && !start_i;
  assign idx_w       = idx_q[IdxW-1:0];
  assign cur_e       = dpb_q[idx_w];
  assign ref_e       = dpb_q[ref_q];
  assign cap_c       = (cap_q == 5'd0) ? 5'd1 : ((cap_q > 5'(DpbDepth)) ? 5'(DpbDepth) : cap_q);

  hgdt_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_MOD_P;
      ST_MOD_P:  if (drsp.done || p_per_q == 8'd0 || gop_pos_q == 32'd0) state_d = ST_KIND;
      ST_KIND:   state_d = (kind_d == KIND_P && item_q.use_ltr) ? ST_PRUNE : ST_MAX;
      ST_PRUNE:  if (idx_q >= cnt_q) state_d = ST_MAX;
      ST_MAX:    if (kind_q != KIND_P || idx_q >= cnt_q) state_d = ST_EMIT;
      ST_EMIT:   if (idx_q >= cnt_q) state_d = ST_EVICT;
      ST_EVICT:  if (cnt_q < CntW'(cap_c) || idx_q >= cnt_q || !cur_e.is_long) state_d = ST_REUSE;
      ST_REUSE:  if (!is_long_q || !act_mask_q[cur_slot_q] || idx_q >= cnt_q ||
                     (cur_e.is_long && cur_e.slot == cur_slot_q)) state_d = ST_APPEND;
      ST_APPEND: state_d = ST_MOD_G;
      ST_MOD_G:  if (drsp.done || gop_len_q == 16'd0) state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    gop_pos_d   = gop_pos_q;
    poc_d       = poc_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    cur_slot_d  = cur_slot_q;
    act_mask_d  = act_mask_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    is_long_d   = is_long_q;
    idx_d       = idx_q;
    ref_d       = ref_q;
    ref_valid_d = ref_valid_q;
    ref_err_d   = ref_err_q;
    used_d      = used_q;
    rem_zero_d  = rem_zero_q;
    rm_en       = 1'b0;
    rm_pos      = idx_w;
    app_en      = 1'b0;
    dreq        = '0;
    out_valid_o = 1'b0;
    out_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (in_i.mark_ltr && !pend_q) begin
            pend_d      = 1'b1;
            pend_slot_d = in_i.mark_ltr_slot;
          end
          dreq.start    = 1'b1;
          dreq.dividend = gop_pos_q;
          dreq.divisor  = {24'd0, p_per_q};
        end
      end
      ST_MOD_P: rem_zero_d = drsp.rem == 32'd0;
      ST_KIND: begin
        if (gop_pos_q == 32'd0) kind_d = KIND_IDR;
        else if (p_per_q == 8'd0) kind_d = KIND_I;
        else kind_d = rem_zero_q ? KIND_P : KIND_B;
        if (item_q.force_key || kind_d == KIND_IDR) begin
          kind_d     = KIND_IDR;
          gop_pos_d  = '0;
          poc_d      = '0;
          cur_slot_d = '0;
          cnt_d      = '0;
          act_mask_d = '0;
        end else begin
          poc_d = poc_q + 32'd1;
        end
        is_long_d = 1'b0;
        if (max_lt_q != 5'd0 && pend_q) begin
          is_long_d  = 1'b1;
          cur_slot_d = pend_slot_q;
          pend_d     = 1'b0;
        end
        idx_d       = '0;
        ref_d       = '0;
        ref_valid_d = 1'b0;
        ref_err_d   = 1'b0;
        used_d      = '0;
      end
      ST_PRUNE: begin
        if (idx_q < cnt_q) begin
          if (!cur_e.is_long || !item_q.use_ltr_mask[cur_e.slot]) begin
            rm_en = 1'b1;
            cnt_d = cnt_q - CntW'(1);
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end else begin
          act_mask_d = item_q.use_ltr_mask;
          idx_d      = '0;
        end
      end
      ST_MAX: begin
        if (kind_q == KIND_P && idx_q < cnt_q) begin
          if (idx_q != '0 && cur_e.poc > ref_e.poc) ref_d = idx_w;
          idx_d = idx_q + CntW'(1);
        end else begin
          idx_d = '0;
          if (kind_q == KIND_P) begin
            if (cnt_q == '0) ref_err_d = 1'b1;
            else begin
              ref_valid_d = 1'b1;
              if (ref_e.is_long) used_d = 16'(1) << ref_e.slot;
            end
          end
        end
      end
      ST_EMIT: begin
        out_valid_o            = 1'b1;
        out_o.frame_kind       = kind_q;
        out_o.frame_poc        = poc_q;
        out_o.frame_is_long    = is_long_q;
        out_o.long_term_info   = {used_q, is_long_q ? {12'd0, cur_slot_q} : 16'hFFFF};
        out_o.ref_position     = 5'(ref_q);
        out_o.ref_valid        = ref_valid_q;
        out_o.ref_error        = ref_err_q;
        if (idx_q >= cnt_q) begin
          out_o.entry_poc        = poc_q;
          out_o.entry_is_long    = is_long_q;
          out_o.entry_dirty_num  = item_q.dirty_frame_num;
          out_o.entry_is_current = 1'b1;
          out_o.last             = 1'b1;
          idx_d                  = '0;
        end else begin
          out_o.entry_poc       = cur_e.poc;
          out_o.entry_is_long   = cur_e.is_long;
          out_o.entry_dirty_num = cur_e.dirty;
          idx_d                 = idx_q + CntW'(1);
        end
      end
      ST_EVICT: begin
        if (cnt_q >= CntW'(cap_c)) begin
          if (idx_q >= cnt_q) begin
            rm_en  = 1'b1;
            rm_pos = '0;
            cnt_d  = cnt_q - CntW'(1);
            idx_d  = '0;
          end else if (!cur_e.is_long) begin
            rm_en = 1'b1;
            cnt_d = cnt_q - CntW'(1);
            idx_d = '0;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end else begin
          idx_d = '0;
        end
      end
      ST_REUSE: begin
        if (is_long_q && act_mask_q[cur_slot_q] && idx_q < cnt_q) begin
          if (cur_e.is_long && cur_e.slot == cur_slot_q) begin
            rm_en = 1'b1;
            cnt_d = cnt_q - CntW'(1);
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
        if (state_d == ST_APPEND && is_long_q)
          act_mask_d = act_mask_q | (16'(1) << cur_slot_q);
      end
      ST_APPEND: begin
        if (cnt_q < CntW'(DpbDepth)) begin
          app_en = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
        end
        dreq.start    = gop_len_q != 16'd0;
        dreq.dividend = gop_pos_q;
        dreq.divisor  = {16'd0, gop_len_q};
      end
      ST_MOD_G: begin
        // Advance as (position mod L) + 1, folding L back to zero
        if (gop_len_q == 16'd0) gop_pos_d = gop_pos_q + 32'd1;
        else if (drsp.done)
          gop_pos_d = (drsp.rem + 32'd1 == {16'd0, gop_len_q}) ? 32'd0 : drsp.rem + 32'd1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gop_len_q   <= 16'd0;
      p_per_q     <= 8'd1;
      cap_q       <= 5'd16;
      max_lt_q    <= 5'd0;
      gop_pos_q   <= '0;
      poc_q       <= '0;
      pend_q      <= 1'b0;
      pend_slot_q <= '0;
      cur_slot_q  <= '0;
      act_mask_q  <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      gop_pos_q   <= gop_pos_d;
      poc_q       <= poc_d;
      pend_q      <= pend_d;
      pend_slot_q <= pend_slot_d;
      cur_slot_q  <= cur_slot_d;
      act_mask_q  <= act_mask_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GOP_LENGTH: gop_len_q <= cfg_data_i[15:0];
          REG_P_PERIOD:   p_per_q   <= cfg_data_i[7:0];
          REG_DPB_CAP:    cap_q     <= cfg_data_i[4:0];
          REG_MAX_LONG:   max_lt_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_i;
    kind_q      <= kind_d;
    is_long_q   <= is_long_d;
    ref_q       <= ref_d;
    ref_valid_q <= ref_valid_d;
    ref_err_q   <= ref_err_d;
    used_q      <= used_d;
    rem_zero_q  <= rem_zero_d;
    // Shift store: close a gap or append at the fill count
    for (int k = 0; k < DpbDepth; k++) begin
      if (rm_en && IdxW'(k) >= rm_pos && k + 1 < DpbDepth)
        dpb_q[k] <= dpb_q[k + 1];
      else if (app_en && CntW'(k) == cnt_q) begin
        dpb_q[k].poc     <= poc_q;
        dpb_q[k].is_long <= is_long_q;
        dpb_q[k].slot    <= cur_slot_q;
        dpb_q[k].dirty   <= item_q.dirty_frame_num;
      end
    end
  end

endmodule

>>> tb/hgdt_frame_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgdt_frame_scoreboard: predicts and checks the GOP and DPB tracker
// Follows register writes and accepted frames to keep a shadow copy of the
// GOP position, POC, long-term marks and DPB store. Each frame is expanded
// into its expected snapshot entries, and each result is checked in order.
// ----------------------------------------------------------------------------
module hgdt_frame_scoreboard (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  hgdt_pkg::in_item_t   in_i,
  input  logic                 busy_o,
  input  logic                 out_valid_o,
  input  hgdt_pkg::out_item_t  out_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import hgdt_pkg::*;

  // shadow registers
  logic [15:0] gop_length;
  logic [7:0]  p_period;
  logic [4:0]  dpb_capacity;
  logic [4:0]  max_long_term;

  // shadow tracker state
  logic [31:0] gop_pos;
  logic [31:0] poc_cnt;
  logic        pend_mark;
  logic [3:0]  pend_slot;
  logic [3:0]  cur_slot;
  logic [15:0] act_mask;
  int          dpb_cnt;
  logic [31:0] ent_poc   [DpbDepth];
  logic        ent_long  [DpbDepth];
  logic [3:0]  ent_slot  [DpbDepth];
  logic [31:0] ent_dirty [DpbDepth];

  out_item_t   snapshot_q[$];
  int          fails;

  task automatic drop_entry(input int pos);
    for (int i = pos; i + 1 < dpb_cnt; i++) begin
      ent_poc[i]   = ent_poc[i + 1];
      ent_long[i]  = ent_long[i + 1];
      ent_slot[i]  = ent_slot[i + 1];
      ent_dirty[i] = ent_dirty[i + 1];
    end
    if (dpb_cnt > 0) dpb_cnt--;
  endtask

  task automatic track_frame(input in_item_t f);
    logic [1:0]  kind;
    logic [15:0] used;
    logic [31:0] info;
    int          ref_pos;
    int          cap;
    int          victim;
    int          i;
    logic        is_long;
    logic        has_ref;
    logic        no_ref;
    out_item_t   r;
    used    = '0;
    ref_pos = 0;
    is_long = 1'b0;
    has_ref = 1'b0;
    no_ref  = 1'b0;

    if (f.mark_ltr && !pend_mark) begin
      pend_mark = 1'b1;
      pend_slot = f.mark_ltr_slot;
    end

    if (gop_pos == 0) kind = KIND_IDR;
    else if (p_period == 0) kind = KIND_I;
    else kind = (gop_pos % {24'd0, p_period} == 0) ? KIND_P : KIND_B;

    if (f.force_key || kind == KIND_IDR) begin
      kind     = KIND_IDR;
      gop_pos  = '0;
      poc_cnt  = '0;
      cur_slot = '0;
      dpb_cnt  = 0;
      act_mask = '0;
    end else begin
      poc_cnt = poc_cnt + 1;
    end

    if (max_long_term > 0 && pend_mark) begin
      is_long   = 1'b1;
      cur_slot  = pend_slot;
      pend_mark = 1'b0;
    end

    if (kind == KIND_P) begin
      if (f.use_ltr) begin
        i = 0;
        while (i < dpb_cnt) begin
          if (!ent_long[i] || !f.use_ltr_mask[ent_slot[i]]) drop_entry(i);
          else i++;
        end
        act_mask = f.use_ltr_mask;
      end
      if (dpb_cnt == 0) begin
        no_ref = 1'b1;
      end else begin
        // strict compare keeps the earliest of equal POCs
        for (i = 1; i < dpb_cnt; i++)
          if (ent_poc[i] > ent_poc[ref_pos]) ref_pos = i;
        has_ref = 1'b1;
        if (ent_long[ref_pos]) used = 16'd1 << ent_slot[ref_pos];
      end
    end

    info = {used, is_long ? {12'd0, cur_slot} : 16'hFFFF};

    for (i = 0; i <= dpb_cnt; i++) begin
      r.frame_kind       = kind;
      r.frame_poc        = poc_cnt;
      r.frame_is_long    = is_long;
      r.long_term_info   = info;
      r.ref_position     = 5'(ref_pos);
      r.ref_valid        = has_ref;
      r.entry_is_current = (i == dpb_cnt);
      r.entry_poc        = r.entry_is_current ? poc_cnt : ent_poc[i];
      r.entry_is_long    = r.entry_is_current ? is_long : ent_long[i];
      r.entry_dirty_num  = r.entry_is_current ? f.dirty_frame_num : ent_dirty[i];
      r.ref_error        = no_ref;
      r.last             = r.entry_is_current;
      snapshot_q = {snapshot_q, r};
    end

    cap = dpb_capacity;
    if (cap < 1) cap = 1;
    if (cap > DpbDepth) cap = DpbDepth;
    if (dpb_cnt >= cap) begin
      // oldest short-term goes; with none, the oldest entry goes
      victim = 0;
      for (i = 0; i < dpb_cnt; i++)
        if (!ent_long[i]) begin
          victim = i;
          break;
        end
      drop_entry(victim);
    end

    if (is_long) begin
      if (act_mask[cur_slot]) begin
        for (i = 0; i < dpb_cnt; i++)
          if (ent_long[i] && ent_slot[i] == cur_slot) begin
            drop_entry(i);
            break;
          end
      end
      act_mask[cur_slot] = 1'b1;
    end

    if (dpb_cnt < DpbDepth) begin
      ent_poc[dpb_cnt]   = poc_cnt;
      ent_long[dpb_cnt]  = is_long;
      ent_slot[dpb_cnt]  = cur_slot;
      ent_dirty[dpb_cnt] = f.dirty_frame_num;
      dpb_cnt++;
    end

    if (gop_length > 0) gop_pos = 32'(({1'b0, gop_pos} + 33'd1) % {17'd0, gop_length});
    else gop_pos = gop_pos + 1;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  task automatic check_entry(input out_item_t act);
    out_item_t e;
    if (snapshot_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, act);
      fails++;
      return;
    end
    e = snapshot_q.pop_front();
    cmp_field("frame_kind", 32'(e.frame_kind), 32'(act.frame_kind));
    cmp_field("frame_poc", e.frame_poc, act.frame_poc);
    cmp_field("frame_is_long", 32'(e.frame_is_long), 32'(act.frame_is_long));
    cmp_field("long_term_info", e.long_term_info, act.long_term_info);
    cmp_field("ref_position", 32'(e.ref_position), 32'(act.ref_position));
    cmp_field("ref_valid", 32'(e.ref_valid), 32'(act.ref_valid));
    cmp_field("entry_poc", e.entry_poc, act.entry_poc);
    cmp_field("entry_is_long", 32'(e.entry_is_long), 32'(act.entry_is_long));
    cmp_field("entry_dirty_num", e.entry_dirty_num, act.entry_dirty_num);
    cmp_field("entry_is_current", 32'(e.entry_is_current), 32'(act.entry_is_current));
    cmp_field("ref_error", 32'(e.ref_error), 32'(act.ref_error));
    cmp_field("last", 32'(e.last), 32'(act.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gop_length    = '0;
      p_period      = 8'd1;
      dpb_capacity  = 5'd16;
      max_long_term = '0;
      gop_pos       = '0;
      poc_cnt       = '0;
      pend_mark     = 1'b0;
      pend_slot     = '0;
      cur_slot      = '0;
      act_mask      = '0;
      dpb_cnt       = 0;
      snapshot_q.delete();
      fails         = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GOP_LENGTH: gop_length    = cfg_data_i[15:0];
          REG_P_PERIOD:   p_period      = cfg_data_i[7:0];
          REG_DPB_CAP:    dpb_capacity  = cfg_data_i[4:0];
          REG_MAX_LONG:   max_long_term = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) track_frame(in_i);
      if (out_valid_o) check_entry(out_o);
    end
    fail_count_o <= fails;
    pending_o    <= snapshot_q.size();
  end

endmodule

>>> tb/hevc_gop_and_dpb_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_gop_and_dpb_tracker_tb: frame sequence test for the GOP/DPB tracker
// Runs directed frames and then random frame streams under several register
// settings and sender idle rates; the scoreboard checks every snapshot entry.
// ----------------------------------------------------------------------------
module hevc_gop_and_dpb_tracker_tb;
  import hgdt_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  in_item_t    in_i;
  logic        busy_o;
  logic        out_valid_o;
  out_item_t   out_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          idle_pct;
  int          max_lt;

  hevc_gop_and_dpb_tracker DUT (
    .clk_i, .rst_ni, .start_i, .in_i, .busy_o, .out_valid_o, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  hgdt_frame_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .start_i, .in_i, .busy_o, .out_valid_o, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("hevc_gop_and_dpb_tracker_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input int gop, input int pp, input int cap, input int mlt);
    write_reg(REG_GOP_LENGTH, gop);
    write_reg(REG_P_PERIOD, pp);
    write_reg(REG_DPB_CAP, cap);
    write_reg(REG_MAX_LONG, mlt);
    max_lt = mlt;
  endtask

  // start stays high across back-to-back frames
  task automatic send_frame(input logic fk, input logic ml, input logic [3:0] slot,
                            input logic ul, input logic [15:0] mask,
                            input logic [31:0] dirty);
    int gap;
    start_i <= 1'b1;
    in_i    <= '{fk, ml, slot, ul, mask, dirty};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      // hold start low until the block is idle, then wait out the random gap
      start_i <= 1'b0;
      @(posedge clk_i);
      while (busy_o) @(posedge clk_i);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_frames(input int count);
    logic [3:0] slot;
    logic [15:0] mask;
    for (int n = 0; n < count; n++) begin
      slot = ($urandom_range(3) != 0 && max_lt > 0) ? 4'($urandom_range(max_lt - 1))
                                                    : 4'($urandom_range(15));
      mask = $urandom_range(1) ? 16'($urandom_range(16'hFFFF)) : 16'hFFFF;
      send_frame($urandom_range(19) == 0, $urandom_range(9) < 3, slot,
                 $urandom_range(9) < 3, mask, $urandom);
    end
  endtask

  initial begin
    int gop_tab [6] = '{0, 8, 65535, 0, 5, 12};
    int pp_tab  [6] = '{1, 3, 255, 0, 2, 4};
    int cap_tab [6] = '{16, 4, 1, 0, 16, 6};
    int mlt_tab [6] = '{0, 4, 16, 16, 16, 2};
    int idl_tab [6] = '{0, 56, 14, 56, 0, 14};
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    idle_pct    = 0;
    max_lt      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, mark held while long-term marking is off
    send_frame(1'b0, 1'b1, 4'd15, 1'b0, 16'h0000, 32'h0000_0000);
    send_frame(1'b0, 1'b1, 4'd3, 1'b1, 16'h0000, 32'hFFFF_FFFF);
    send_frame(1'b0, 1'b0, 4'd0, 1'b0, 16'hFFFF, 32'h1234_5678);
    send_frame(1'b1, 1'b0, 4'd0, 1'b0, 16'h0000, 32'hA5A5_A5A5);
    drain();
    set_regs(6, 2, 3, 16);
    // pending mark applies, slot reuse, pruning to selected long-terms
    send_frame(1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd1);
    send_frame(1'b0, 1'b1, 4'd15, 1'b0, 16'h0000, 32'd2);
    send_frame(1'b0, 1'b1, 4'd5, 1'b1, 16'h8000, 32'd3);
    send_frame(1'b0, 1'b1, 4'd5, 1'b0, 16'h0000, 32'd4);
    send_frame(1'b0, 1'b1, 4'd5, 1'b1, 16'h0020, 32'd5);
    send_frame(1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd6);
    send_frame(1'b0, 1'b0, 4'd0, 1'b1, 16'h0000, 32'd7);
    send_frame(1'b0, 1'b1, 4'd0, 1'b1, 16'hFFFF, 32'd8);
    send_frame(1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd9);
    send_frame(1'b0, 1'b0, 4'd0, 1'b1, 16'h0000, 32'd10);
    // IDR, then a pruned-empty P frame gives a reference error
    send_frame(1'b1, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd11);
    send_frame(1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd12);
    send_frame(1'b0, 1'b0, 4'd0, 1'b1, 16'h0000, 32'd13);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_regs(gop_tab[ph], pp_tab[ph], cap_tab[ph], mlt_tab[ph]);
      idle_pct = idl_tab[ph];
      random_frames(40);
      drain();
    end

    if (fail_count == 0) begin
      $display("hevc_gop_and_dpb_tracker_tb: PASS");
    end else begin
      $display("hevc_gop_and_dpb_tracker_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/hgdt_pkg.sv
sv/hgdt_mod.sv
sv/hevc_gop_and_dpb_tracker.sv
tb/hgdt_frame_scoreboard.sv
tb/hevc_gop_and_dpb_tracker_tb.sv
